### rtl/assert_macros.svh
// Assertion macros shared by the RTL of the divisor sum block.
// Depends on a clock named clk and an active-low reset named rst_n in scope.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// The property must hold at every clock edge outside reset.
`define ASSERT_CLK(lbl, prop, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (prop)) else $error(msg);

// The condition must never be seen at a clock edge outside reset.
`define ASSERT_NEVER(lbl, cond, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) !(cond)) else $error(msg);

`endif

### rtl/dspm_pkg.sv
// Package for the divisor sum block: widths, reset value and sequencer codes.
// Used by divisor_sum_of_power_mod; depends on nothing.
`timescale 1ns / 1ps
`default_nettype none
package dspm_pkg;
    localparam int VALUE_W = 26;
    localparam int MOD_W   = 16;
    localparam int ROOT_W  = VALUE_W / 2 + 1;
    localparam int DVS_W   = (MOD_W > ROOT_W) ? MOD_W : ROOT_W;
    localparam int DIVD_W  = (2 * MOD_W > VALUE_W) ? 2 * MOD_W : VALUE_W;
    localparam int CNT_W   = $clog2(DIVD_W + 1);
    localparam int S_W     = $clog2(VALUE_W + 1);
    localparam int K_W     = VALUE_W + S_W;
    localparam int BIT_W   = $clog2(K_W);

    localparam logic [MOD_W-1:0] MODULUS_RESET = MOD_W'(9901);

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_SQ,
        ST_DIV,
        ST_MUL,
        ST_FIN
    } state_t;

    typedef enum logic [2:0] {
        OP_TRIAL,
        OP_PM,
        OP_S2,
        OP_PW2,
        OP_PWP,
        OP_RES
    } op_t;
endpackage
`default_nettype wire

### rtl/divisor_sum_of_power_mod.sv
// Top level of the divisor sum block: sequencer around one shared divider and multiplier.
// Depends on dspm_pkg and assert_macros.svh.
//
// channel  direction  handshake             payload
// in       input      in_valid / in_ready   base_value, power_exponent
// cfg      input      cfg_valid / cfg_ready cfg_data (modulus)
// out      output     out_valid / out_ready divisor_sum
//
// The block takes one word at a time. Each trial divisor costs one square check and one divide
// in the shared restoring divider, and each prime costs 31 exponent bits of up to three modular
// products.
// Reset sets the modulus to 9901 and empties the output register.
// A result waiting in the output register holds back only the next finished word.
`timescale 1ns / 1ps
`default_nettype none
`include "assert_macros.svh"
module divisor_sum_of_power_mod (
    input  wire                            clk,
    input  wire                            rst_n,
    input  wire                            in_valid,
    output logic                           in_ready,
    input  wire  [dspm_pkg::VALUE_W-1:0]   base_value,
    input  wire  [dspm_pkg::VALUE_W-1:0]   power_exponent,
    input  wire                            cfg_valid,
    output logic                           cfg_ready,
    input  wire  [dspm_pkg::MOD_W-1:0]     cfg_data,
    output logic                           out_valid,
    input  wire                            out_ready,
    output logic [dspm_pkg::MOD_W-1:0]     divisor_sum
);
    import dspm_pkg::*;

    state_t             state_reg, state_next;
    op_t                op_reg, op_next;
    logic [VALUE_W-1:0] a_reg, a_next;
    logic [VALUE_W-1:0] b_reg, b_next;
    logic [ROOT_W-1:0]  i_reg, i_next;
    logic [S_W-1:0]     s_reg, s_next;
    logic [K_W-1:0]     k_reg, k_next;
    logic [BIT_W-1:0]   bit_reg, bit_next;
    logic               last_reg, last_next;
    logic [MOD_W-1:0]   res_reg, res_next;
    logic [MOD_W-1:0]   sg_reg, sg_next;
    logic [MOD_W-1:0]   pw_reg, pw_next;
    logic [MOD_W-1:0]   pm_reg, pm_next;
    logic [DIVD_W-1:0]  q_reg, q_next;
    logic [DVS_W-1:0]   rem_reg, rem_next;
    logic [DVS_W-1:0]   dvs_reg, dvs_next;
    logic [CNT_W-1:0]   cnt_reg, cnt_next;
    logic [MOD_W-1:0]   mod_reg;
    logic               out_valid_reg, out_valid_next;
    logic [MOD_W-1:0]   out_reg, out_next;

    logic [DVS_W:0]      r2;
    logic                ge;
    logic [DVS_W-1:0]    rem_step;
    logic [DIVD_W-1:0]   q_step;
    logic                div_last;
    logic [2*ROOT_W-1:0] i_sq;
    logic                i_fits;
    logic [MOD_W:0]      pw1;
    logic [MOD_W-1:0]    t1;
    logic [MOD_W-1:0]    mul_a, mul_b;
    logic [2*MOD_W-1:0]  prod;
    logic [MOD_W:0]      ssum;
    logic [MOD_W-1:0]    sg_add;
    logic                in_acc;
    logic                start_bad;
    logic                fin_load;

    assign cfg_ready   = 1'b1;
    assign in_ready    = (state_reg == ST_IDLE);
    assign out_valid   = out_valid_reg;
    assign divisor_sum = out_reg;
    assign in_acc      = in_valid && in_ready;
    assign start_bad   = (mod_reg < MOD_W'(2)) || (base_value == '0);
    assign fin_load    = !out_valid_reg || out_ready;

    assign r2       = {rem_reg, q_reg[DIVD_W-1]};
    assign ge       = (r2 >= {1'b0, dvs_reg});
    assign rem_step = ge ? DVS_W'(r2 - {1'b0, dvs_reg}) : r2[DVS_W-1:0];
    assign q_step   = {q_reg[DIVD_W-2:0], ge};
    assign div_last = (cnt_reg == CNT_W'(1));

    assign i_sq   = i_reg * i_reg;
    assign i_fits = (i_sq <= (2*ROOT_W)'(a_reg));

    assign pw1 = {1'b0, pw_reg} + (MOD_W+1)'(1);
    assign t1  = (pw1 == {1'b0, mod_reg}) ? '0 : pw1[MOD_W-1:0];

    always_comb
    begin
        unique case (op_reg)
            OP_S2:   begin mul_a = sg_reg;  mul_b = t1;     end
            OP_PW2:  begin mul_a = pw_reg;  mul_b = pw_reg; end
            OP_PWP:  begin mul_a = pw_reg;  mul_b = pm_reg; end
            OP_RES:  begin mul_a = res_reg; mul_b = sg_reg; end
            default: begin mul_a = '0;      mul_b = '0;     end
        endcase
    end

    assign prod   = mul_a * mul_b;
    assign ssum   = {1'b0, sg_reg} + {1'b0, rem_step[MOD_W-1:0]};
    assign sg_add = (ssum >= {1'b0, mod_reg}) ? MOD_W'(ssum - {1'b0, mod_reg})
                                              : ssum[MOD_W-1:0];

    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            ST_IDLE:
                if (in_acc)
                    state_next = start_bad ? ST_FIN : ST_SQ;
            ST_SQ:
                if (i_fits || (a_reg > VALUE_W'(1)))
                    state_next = ST_DIV;
                else
                    state_next = ST_FIN;
            ST_DIV:
                if (div_last)
                begin
                    priority case (op_reg)
                        OP_TRIAL:
                            if (rem_step == '0 || s_reg != '0)
                                state_next = ST_DIV;
                            else
                                state_next = ST_SQ;
                        OP_RES:
                            state_next = last_reg ? ST_FIN : ST_SQ;
                        default:
                            state_next = ST_MUL;
                    endcase
                end
            ST_MUL:
                state_next = ST_DIV;
            ST_FIN:
                if (fin_load)
                    state_next = ST_IDLE;
            default:
                state_next = ST_IDLE;
        endcase
    end

    always_comb
    begin
        op_next        = op_reg;
        a_next         = a_reg;
        b_next         = b_reg;
        i_next         = i_reg;
        s_next         = s_reg;
        k_next         = k_reg;
        bit_next       = bit_reg;
        last_next      = last_reg;
        res_next       = res_reg;
        sg_next        = sg_reg;
        pw_next        = pw_reg;
        pm_next        = pm_reg;
        q_next         = q_reg;
        rem_next       = rem_reg;
        dvs_next       = dvs_reg;
        cnt_next       = cnt_reg;
        out_next       = out_reg;
        out_valid_next = out_valid_reg && !out_ready;
        unique case (state_reg)
            ST_IDLE:
                if (in_acc)
                begin
                    a_next   = base_value;
                    b_next   = power_exponent;
                    i_next   = ROOT_W'(2);
                    s_next   = '0;
                    res_next = start_bad ? '0 : MOD_W'(1);
                end
            ST_SQ:
                if (i_fits)
                begin
                    op_next  = OP_TRIAL;
                    q_next   = DIVD_W'(a_reg) << (DIVD_W - VALUE_W);
                    rem_next = '0;
                    dvs_next = DVS_W'(i_reg);
                    cnt_next = CNT_W'(VALUE_W);
                end
                else if (a_reg > VALUE_W'(1))
                begin
                    op_next   = OP_PM;
                    q_next    = DIVD_W'(a_reg);
                    rem_next  = '0;
                    dvs_next  = DVS_W'(mod_reg);
                    cnt_next  = CNT_W'(DIVD_W);
                    k_next    = K_W'(b_reg) + K_W'(1);
                    last_next = 1'b1;
                end
            ST_DIV:
            begin
                q_next   = q_step;
                rem_next = rem_step;
                cnt_next = cnt_reg - CNT_W'(1);
                if (div_last)
                begin
                    unique case (op_reg)
                        OP_TRIAL:
                            if (rem_step == '0)
                            begin
                                a_next   = q_step[VALUE_W-1:0];
                                s_next   = s_reg + S_W'(1);
                                q_next   = DIVD_W'(q_step[VALUE_W-1:0]) << (DIVD_W - VALUE_W);
                                rem_next = '0;
                                cnt_next = CNT_W'(VALUE_W);
                            end
                            else if (s_reg != '0)
                            begin
                                op_next   = OP_PM;
                                q_next    = DIVD_W'(i_reg);
                                rem_next  = '0;
                                dvs_next  = DVS_W'(mod_reg);
                                cnt_next  = CNT_W'(DIVD_W);
                                k_next    = K_W'(b_reg) * K_W'(s_reg) + K_W'(1);
                                last_next = 1'b0;
                            end
                            else
                                i_next = i_reg + ROOT_W'(1);
                        OP_PM:
                        begin
                            pm_next  = rem_step[MOD_W-1:0];
                            sg_next  = '0;
                            pw_next  = MOD_W'(1);
                            bit_next = BIT_W'(K_W - 1);
                            op_next  = OP_S2;
                        end
                        OP_S2:
                        begin
                            sg_next = rem_step[MOD_W-1:0];
                            op_next = OP_PW2;
                        end
                        OP_PW2:
                        begin
                            pw_next = rem_step[MOD_W-1:0];
                            if (k_reg[bit_reg])
                            begin
                                sg_next = sg_add;
                                op_next = OP_PWP;
                            end
                            else if (bit_reg == '0)
                                op_next = OP_RES;
                            else
                            begin
                                bit_next = bit_reg - BIT_W'(1);
                                op_next  = OP_S2;
                            end
                        end
                        OP_PWP:
                        begin
                            pw_next = rem_step[MOD_W-1:0];
                            if (bit_reg == '0)
                                op_next = OP_RES;
                            else
                            begin
                                bit_next = bit_reg - BIT_W'(1);
                                op_next  = OP_S2;
                            end
                        end
                        OP_RES:
                        begin
                            res_next = rem_step[MOD_W-1:0];
                            s_next   = '0;
                            if (!last_reg)
                                i_next = i_reg + ROOT_W'(1);
                        end
                        default:
                            op_next = op_reg;
                    endcase
                end
            end
            ST_MUL:
            begin
                q_next   = DIVD_W'(prod);
                rem_next = '0;
                dvs_next = DVS_W'(mod_reg);
                cnt_next = CNT_W'(DIVD_W);
            end
            ST_FIN:
                if (fin_load)
                begin
                    out_next       = res_reg;
                    out_valid_next = 1'b1;
                end
            default:
                op_next = op_reg;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            out_valid_reg <= 1'b0;
            mod_reg       <= MODULUS_RESET;
        end
        else
        begin
            state_reg     <= state_next;
            out_valid_reg <= out_valid_next;
            if (cfg_valid && cfg_ready)
                mod_reg <= cfg_data;
        end
    end

    always_ff @(posedge clk)
    begin
        op_reg   <= op_next;
        a_reg    <= a_next;
        b_reg    <= b_next;
        i_reg    <= i_next;
        s_reg    <= s_next;
        k_reg    <= k_next;
        bit_reg  <= bit_next;
        last_reg <= last_next;
        res_reg  <= res_next;
        sg_reg   <= sg_next;
        pw_reg   <= pw_next;
        pm_reg   <= pm_next;
        q_reg    <= q_next;
        rem_reg  <= rem_next;
        dvs_reg  <= dvs_next;
        cnt_reg  <= cnt_next;
        out_reg  <= out_next;
    end

    `ASSERT_CLK(a_busy_after_accept, (in_valid && in_ready) |=> !in_ready,
                "Block accepted a word while the previous one was in progress.")
    `ASSERT_NEVER(a_div_by_zero, (state_reg == ST_DIV) && (dvs_reg == '0),
                  "Shared divider ran with a zero divisor.")
    `ASSERT_CLK(a_result_range,
                out_valid |-> ((divisor_sum < mod_reg) || (divisor_sum == '0)),
                "Result word is not reduced below the modulus.")
endmodule
`default_nettype wire
